// ===== design/tsrt_pkg.sv =====
// tempo/speed row timer: shared types, codes and constants
// used by tsrt_div and tempo_speed_row_timer_unit; no dependencies
`timescale 1ns / 1ps

package tsrt_pkg;

  // request kinds
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_STEP   = 3'd1;
  localparam logic [2:0] KIND_EFFECT = 3'd2;
  localparam logic [2:0] KIND_GROOVE = 3'd3;
  localparam logic [2:0] KIND_LOAD   = 3'd4;
  localparam logic [2:0] KIND_WR_ENT = 3'd5;
  localparam logic [2:0] KIND_WR_LEN = 3'd6;

  // configuration register indexes
  localparam logic [2:0] CFG_FRAME_RATE = 3'd0;
  localparam logic [2:0] CFG_SPLIT      = 3'd1;
  localparam logic [2:0] CFG_SONG_TEMPO = 3'd2;
  localparam logic [2:0] CFG_SONG_SPEED = 3'd3;
  localparam logic [2:0] CFG_SONG_GRV   = 3'd4;

  // configuration reset values
  localparam logic [7:0] RST_FRAME_RATE = 8'd60;
  localparam logic [7:0] RST_SPLIT      = 8'd32;
  localparam logic [7:0] RST_SONG_TEMPO = 8'd150;
  localparam logic [7:0] RST_SONG_SPEED = 8'd6;

  localparam int RESET_TEMPO = 150;
  localparam int TEMPO_SCALE = 24;
  localparam int FRAME_SCALE = 60;

  // divider geometry: dividend up to 255*24, divisor up to 255
  localparam int PROD_W    = 13;
  localparam int DIVR_W    = 9;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = 4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] param;
    logic [4:0] groove_number;
    logic [6:0] entry_position;
    logic [7:0] groove_length;
  } tsrt_in_t;

  typedef struct packed {
    logic       row_due;
    logic [7:0] current_speed;
    logic [7:0] current_tempo;
    logic       groove_active;
    logic [6:0] groove_position;
  } tsrt_out_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quotient;
    logic [DIVR_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_LOAD,
    ST_TICK_SUB,
    ST_GRV_READ,
    ST_GRV_CHECK,
    ST_SETUP,
    ST_SPD_WAIT,
    ST_POS_START,
    ST_POS_WAIT,
    ST_DONE
  } tsrt_state_t;

  // clamp an 18 bit signed value to the 16 bit range
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] res;
    if (v > 18'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

// ===== design/tsrt_div.sv =====
// tempo/speed row timer: restoring divider, one quotient bit per cycle
// depends on tsrt_pkg
`timescale 1ns / 1ps

module tsrt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tsrt_pkg::div_req_t req,
  output tsrt_pkg::div_rsp_t rsp
);
  import tsrt_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0]    quo_r, quo_nxt;
  logic [DIVR_W-1:0]    rem_r, rem_nxt;
  logic [DIVR_W-1:0]    dvs_r, dvs_nxt;
  logic [DIVR_W:0]      trial;
  logic [DIVR_W:0]      diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[PROD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so it fits DIVR_W bits
      rem_nxt = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      quo_nxt = {quo_r[PROD_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== design/tempo_speed_row_timer_unit.sv =====
// tempo/speed row timer: top level with groove memories and request sequencer
// depends on tsrt_pkg and tsrt_div

`timescale 1ns / 1ps

// One request is handled at a time and gives exactly one result. Before its
// finish state loads the result register, the sequencer passes through:
// - a tick: a reload state, then a subtract state
// - a groove entry or length write, a step row with no groove and the unused
//   kind: no further state
// - a speed/tempo effect: a divider pass for the new ratio, and a track load
//   the same after a read of the groove memories
// - a groove step or groove effect: a memory read, then at most a divider
//   pass for the ratio and a second one for the wrap of the position
// Each new tempo/speed ratio is one pass through the shared serial divider,
// and so is each wrap of the groove position: a start, 13 quotient steps and
// a pick-up of the result. With tempo zero the ratio needs no division. The
// next request is taken in the cycle after a result is loaded. A result that
// still waits in the output register holds the sequencer in its finish state
// until the receiver takes it. The groove entry store and the length store
// are synchronous memories with registered read data. Lengths carry a valid
// bit per groove that reset clears, so no clearing pass is needed. A new
// request is taken while a finished result still waits in the output
// register. Configuration writes are always ready and are not held back
// during a request, so a write takes effect as soon as it is registered.

module tempo_speed_row_timer_unit #(
  parameter int GROOVE_COUNT        = 32,
  parameter int GROOVE_MAX_LENGTH   = 128,
  parameter int DEFAULT_SPEED_VALUE = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsrt_pkg::tsrt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tsrt_pkg::tsrt_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import tsrt_pkg::*;

  localparam int GW        = (GROOVE_COUNT > 1) ? $clog2(GROOVE_COUNT) : 1;
  localparam int PW        = (GROOVE_MAX_LENGTH > 1) ? $clog2(GROOVE_MAX_LENGTH) : 1;
  localparam int LW        = $clog2(GROOVE_MAX_LENGTH + 1);
  localparam int ENT_DEPTH = GROOVE_COUNT * GROOVE_MAX_LENGTH;
  localparam int EAW       = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
  localparam int RST_DEC   = (RESET_TEMPO * TEMPO_SCALE) / DEFAULT_SPEED_VALUE;
  localparam int RST_REM   = (RESET_TEMPO * TEMPO_SCALE) % DEFAULT_SPEED_VALUE;

  // configuration registers
  logic [7:0] frame_rate_r, split_r, song_tempo_r, song_speed_r;
  logic       song_grv_r;

  // timing state
  tsrt_state_t        state_r, state_nxt;
  logic [2:0]         kind_r, kind_nxt;
  logic signed [15:0] acc_r, acc_nxt;
  logic [PROD_W-1:0]  dec_r, dec_nxt;
  logic [7:0]         rem_r, rem_nxt;
  logic [7:0]         tempo_r, tempo_nxt;
  logic [7:0]         speed_r, speed_nxt;
  logic               groove_on_r, groove_on_nxt;
  logic [GW-1:0]      active_r, active_nxt;
  logic [PW-1:0]      position_r, position_nxt;
  logic [GW-1:0]      cand_r, cand_nxt;
  logic               cand_ok_r, cand_ok_nxt;

  // result register
  logic      out_valid_r, out_valid_nxt;
  tsrt_out_t out_data_r;
  logic      out_load;

  // groove memories
  logic [7:0]    ent_mem [ENT_DEPTH];
  logic [7:0]    ent_rd_r;
  logic [LW-1:0] len_mem [GROOVE_COUNT];
  logic [LW-1:0] len_rd_r;
  logic          len_vld_r [GROOVE_COUNT];
  logic          len_vld_rd_r;
  logic [LW-1:0] len_val;

  logic           in_fire;
  logic           rd_en;
  logic           step_pos;
  logic           present;
  logic [EAW-1:0] ent_raddr;
  logic [EAW-1:0] ent_waddr;
  logic           ent_we;
  logic           len_we;
  logic [GW-1:0]  len_widx;
  logic [LW-1:0]  len_wdata;

  logic [13:0]        reload_add;
  logic signed [17:0] tick_sum;
  logic signed [17:0] tick_sub;
  logic [7:0]         div_speed;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tsrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rate_r <= RST_FRAME_RATE;
      split_r      <= RST_SPLIT;
      song_tempo_r <= RST_SONG_TEMPO;
      song_speed_r <= RST_SONG_SPEED;
      song_grv_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_RATE: frame_rate_r <= cfg_data;
        CFG_SPLIT:      split_r      <= cfg_data;
        CFG_SONG_TEMPO: song_tempo_r <= cfg_data;
        CFG_SONG_SPEED: song_speed_r <= cfg_data;
        CFG_SONG_GRV:   song_grv_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // groove entry store: written straight from the request, read in ST_GRV_READ
  assign ent_we    = in_fire && (in_data.kind == KIND_WR_ENT)
                     && (32'(in_data.groove_number) < GROOVE_COUNT)
                     && (32'(in_data.entry_position) < GROOVE_MAX_LENGTH);
  assign ent_waddr = EAW'(32'(in_data.groove_number) * GROOVE_MAX_LENGTH
                          + 32'(in_data.entry_position));
  // step rows read at the current position, effects and loads at entry zero
  assign ent_raddr = EAW'(32'(cand_r) * GROOVE_MAX_LENGTH
                          + ((kind_r == KIND_STEP) ? 32'(position_r) : 32'd0));
  assign rd_en     = (state_r == ST_GRV_READ);

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= in_data.param;
    end
    if (rd_en) begin
      ent_rd_r <= ent_mem[ent_raddr];
    end
  end

  // groove length store with per-groove valid bits
  assign len_we    = in_fire && (in_data.kind == KIND_WR_LEN)
                     && (32'(in_data.groove_number) < GROOVE_COUNT);
  assign len_widx  = GW'(in_data.groove_number);
  assign len_wdata = (32'(in_data.groove_length) > GROOVE_MAX_LENGTH)
                     ? LW'(GROOVE_MAX_LENGTH) : LW'(in_data.groove_length);

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_widx] <= len_wdata;
    end
    if (rd_en) begin
      len_rd_r <= len_mem[cand_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GROOVE_COUNT; i++) begin
        len_vld_r[i] <= 1'b0;
      end
      len_vld_rd_r <= 1'b0;
    end else begin
      if (len_we) begin
        len_vld_r[len_widx] <= 1'b1;
      end
      if (rd_en) begin
        len_vld_rd_r <= len_vld_r[cand_r];
      end
    end
  end

  // a never-written length reads as zero, i.e. groove absent
  assign len_val = len_vld_rd_r ? len_rd_r : '0;
  assign present = cand_ok_r && (len_val != '0);
  assign step_pos = (kind_r == KIND_STEP) || (kind_r == KIND_GROOVE);

  // tick arithmetic: reload then subtract, each saturated to 16 bits
  assign reload_add = (tempo_r != 8'd0) ? 14'(32'(frame_rate_r) * FRAME_SCALE)
                                        : 14'(speed_r);
  assign tick_sum   = 18'(acc_r) + $signed({4'b0, reload_add}) - $signed({10'b0, rem_r});
  assign tick_sub   = 18'(acc_r) - $signed({5'b0, dec_r});
  // speed zero divides as one
  assign div_speed  = (speed_r == 8'd0) ? 8'd1 : speed_r;

  // request sequencer
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    acc_nxt       = acc_r;
    dec_nxt       = dec_r;
    rem_nxt       = rem_r;
    tempo_nxt     = tempo_r;
    speed_nxt     = speed_r;
    groove_on_nxt = groove_on_r;
    active_nxt    = active_r;
    position_nxt  = position_r;
    cand_nxt      = cand_r;
    cand_ok_nxt   = cand_ok_r;
    div_req       = '0;
    out_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          kind_nxt = in_data.kind;
          case (in_data.kind)
            KIND_TICK: begin
              state_nxt = ST_TICK_LOAD;
            end
            KIND_STEP: begin
              cand_nxt    = active_r;
              cand_ok_nxt = 1'b1;
              state_nxt   = groove_on_r ? ST_GRV_READ : ST_DONE;
            end
            KIND_EFFECT: begin
              if ((tempo_r != 8'd0) && (in_data.param >= split_r)) begin
                tempo_nxt = in_data.param;
              end else begin
                speed_nxt     = in_data.param;
                groove_on_nxt = 1'b0;
              end
              state_nxt = ST_SETUP;
            end
            KIND_GROOVE: begin
              cand_nxt    = GW'(in_data.param);
              cand_ok_nxt = 32'(in_data.param) < GROOVE_COUNT;
              state_nxt   = ST_GRV_READ;
            end
            KIND_LOAD: begin
              speed_nxt   = song_speed_r;
              tempo_nxt   = song_tempo_r;
              acc_nxt     = '0;
              cand_nxt    = GW'(song_speed_r);
              cand_ok_nxt = 32'(song_speed_r) < GROOVE_COUNT;
              state_nxt   = ST_GRV_READ;
            end
            default: begin
              // memory writes and the unused kind only report the state
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_TICK_LOAD: begin
        if (acc_r <= 16'sd0) begin
          acc_nxt = sat16(tick_sum);
        end
        state_nxt = ST_TICK_SUB;
      end

      ST_TICK_SUB: begin
        acc_nxt   = sat16(tick_sub);
        state_nxt = ST_DONE;
      end

      ST_GRV_READ: begin
        state_nxt = ST_GRV_CHECK;
      end

      ST_GRV_CHECK: begin
        case (kind_r)
          KIND_STEP: begin
            speed_nxt = ent_rd_r;
            state_nxt = ST_SETUP;
          end
          KIND_GROOVE: begin
            if (present) begin
              groove_on_nxt = 1'b1;
              active_nxt    = cand_r;
              position_nxt  = '0;
              speed_nxt     = ent_rd_r;
              state_nxt     = ST_SETUP;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: begin
            // track load: start on the groove if the song uses one and it exists
            if (song_grv_r && present) begin
              groove_on_nxt = 1'b1;
              active_nxt    = cand_r;
              position_nxt  = '0;
              speed_nxt     = ent_rd_r;
            end else begin
              groove_on_nxt = 1'b0;
              if (song_grv_r) begin
                speed_nxt = 8'(DEFAULT_SPEED_VALUE);
              end
            end
            state_nxt = ST_SETUP;
          end
        endcase
      end

      ST_SETUP: begin
        if (tempo_r == 8'd0) begin
          dec_nxt   = PROD_W'(1);
          rem_nxt   = '0;
          state_nxt = step_pos ? ST_POS_START : ST_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = PROD_W'(32'(tempo_r) * TEMPO_SCALE);
          div_req.divisor  = DIVR_W'(div_speed);
          state_nxt        = ST_SPD_WAIT;
        end
      end

      ST_SPD_WAIT: begin
        if (div_rsp.done) begin
          dec_nxt   = div_rsp.quotient;
          rem_nxt   = div_rsp.remainder[7:0];
          state_nxt = step_pos ? ST_POS_START : ST_DONE;
        end
      end

      ST_POS_START: begin
        // position wraps modulo the length stored at the time of the step
        if (len_val == '0) begin
          position_nxt = '0;
          state_nxt    = ST_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = PROD_W'(32'(position_r) + 32'd1);
          div_req.divisor  = DIVR_W'(len_val);
          state_nxt        = ST_POS_WAIT;
        end
      end

      ST_POS_WAIT: begin
        if (div_rsp.done) begin
          position_nxt = PW'(div_rsp.remainder);
          state_nxt    = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= KIND_TICK;
      acc_r       <= '0;
      dec_r       <= PROD_W'(RST_DEC);
      rem_r       <= 8'(RST_REM);
      tempo_r     <= 8'(RESET_TEMPO);
      speed_r     <= 8'(DEFAULT_SPEED_VALUE);
      groove_on_r <= 1'b0;
      active_r    <= '0;
      position_r  <= '0;
      cand_r      <= '0;
      cand_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      acc_r       <= acc_nxt;
      dec_r       <= dec_nxt;
      rem_r       <= rem_nxt;
      tempo_r     <= tempo_nxt;
      speed_r     <= speed_nxt;
      groove_on_r <= groove_on_nxt;
      active_r    <= active_nxt;
      position_r  <= position_nxt;
      cand_r      <= cand_nxt;
      cand_ok_r   <= cand_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register, payload needs no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.row_due         <= (acc_r <= 16'sd0);
      out_data_r.current_speed   <= speed_r;
      out_data_r.current_tempo   <= tempo_r;
      out_data_r.groove_active   <= groove_on_r;
      out_data_r.groove_position <= 7'(position_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // divider is only started when it is free
  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // with tempo zero the ratio is fixed at one, no remainder
  a_tempo_zero_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && tempo_r == 8'd0) |-> (dec_r == PROD_W'(1) && rem_r == 8'd0))
    else $error("decrement out of step with zero tempo");

  // a new result only appears after the sequencer finishes a request
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the finish state");

  // an active groove always names a groove and a position within the table range
  a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    groove_on_r |-> (32'(active_r) < GROOVE_COUNT && 32'(position_r) < GROOVE_MAX_LENGTH))
    else $error("active groove or position out of range");

endmodule

// ===== sim/tempo_speed_row_timer_unit_test.sv =====
// self-checking testbench for the tempo/speed row timer: directed and random requests
// with an in-bench predictor; depends on tsrt_pkg and tempo_speed_row_timer_unit

`timescale 1ns / 1ps

module tempo_speed_row_timer_unit_test;
  import tsrt_pkg::*;

  localparam int GROOVE_COUNT        = 32;
  localparam int GROOVE_MAX_LENGTH   = 128;
  localparam int DEFAULT_SPEED_VALUE = 6;
  // kind code with no meaning in the block, it only reports the state
  localparam logic [2:0] KIND_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_LENGTH = 300;
  localparam int DRAIN_CYCLES = 50;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  tsrt_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tsrt_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0] cfg_index = CFG_FRAME_RATE;
  logic [7:0] cfg_data = '0;

  tempo_speed_row_timer_unit #(
    .GROOVE_COUNT       (GROOVE_COUNT),
    .GROOVE_MAX_LENGTH  (GROOVE_MAX_LENGTH),
    .DEFAULT_SPEED_VALUE(DEFAULT_SPEED_VALUE)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // register copies, shared by the predictor and the request generator;
  // they only change while the block is idle
  // ---------------------------------------------------------------------------
  logic [7:0] frame_rate_cfg;
  logic [7:0] split_cfg;
  logic [7:0] song_tempo_cfg;
  logic [7:0] song_speed_cfg;
  logic       song_groove_cfg;

  // predictor state for the row timer
  logic signed [15:0] acc_q;
  logic [12:0]        decr_q;
  logic [7:0]         rem_q;
  logic [7:0]         tempo_q;
  logic [7:0]         speed_q;
  logic               grv_on_q;
  logic [4:0]         grv_sel_q;
  logic [6:0]         grv_pos_q;
  logic [7:0]         groove_speed_mem [0:GROOVE_COUNT*GROOVE_MAX_LENGTH-1];
  logic [7:0]         groove_len_mem   [0:GROOVE_COUNT-1];

  tsrt_in_t  pending_requests[$];
  tsrt_out_t expected_timer_states[$];
  // entries the generator has already written, so no unwritten entry gets read
  bit        written_map [0:GROOVE_COUNT*GROOVE_MAX_LENGTH-1];

  int fault_count = 0;
  int cycle_count = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  int in_pause = 0;
  int out_pause = 0;
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] clamp_acc(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // decrement and remainder from the tempo/speed ratio; speed zero divides by one
  task automatic recompute_ratio();
    int prod;
    int divisor;
    if (tempo_q != 0) begin
      divisor = (speed_q == 0) ? 1 : int'(speed_q);
      prod    = int'(tempo_q) * TEMPO_SCALE;
      decr_q  = 13'(prod / divisor);
      rem_q   = 8'(prod % divisor);
    end else begin
      decr_q = 13'd1;
      rem_q  = 8'd0;
    end
  endtask

  task automatic load_groove_speed();
    speed_q = groove_speed_mem[{grv_sel_q, grv_pos_q}];
    recompute_ratio();
  endtask

  // take the speed of the current entry, then move on using the length stored now
  task automatic advance_groove();
    int len;
    load_groove_speed();
    len = int'(groove_len_mem[grv_sel_q]);
    grv_pos_q = (len != 0) ? 7'((int'(grv_pos_q) + 1) % len) : 7'd0;
  endtask

  task automatic advance_row_timer(input tsrt_in_t req, output tsrt_out_t res);
    int sum;
    case (req.kind)
      KIND_TICK: begin
        // reload only once the row has fallen due
        if (acc_q <= 0) begin
          sum = int'(acc_q) - int'(rem_q) +
                ((tempo_q != 0) ? FRAME_SCALE * int'(frame_rate_cfg) : int'(speed_q));
          acc_q = clamp_acc(sum);
        end
        acc_q = clamp_acc(int'(acc_q) - int'(decr_q));
      end
      KIND_STEP: begin
        if (grv_on_q) advance_groove();
      end
      KIND_EFFECT: begin
        // high values set the tempo, unless timing is speed-only
        if (tempo_q != 0 && req.param >= split_cfg) begin
          tempo_q = req.param;
        end else begin
          speed_q  = req.param;
          grv_on_q = 1'b0;
        end
        recompute_ratio();
      end
      KIND_GROOVE: begin
        // absent grooves leave everything as it was
        if (req.param < GROOVE_COUNT && groove_len_mem[req.param[4:0]] != 0) begin
          grv_on_q  = 1'b1;
          grv_sel_q = req.param[4:0];
          grv_pos_q = 7'd0;
          advance_groove();
        end
      end
      KIND_LOAD: begin
        speed_q = song_speed_cfg;
        tempo_q = song_tempo_cfg;
        acc_q   = 16'sd0;
        if (song_groove_cfg && speed_q < GROOVE_COUNT && groove_len_mem[speed_q[4:0]] != 0) begin
          grv_on_q  = 1'b1;
          grv_sel_q = speed_q[4:0];
          grv_pos_q = 7'd0;
          load_groove_speed();
        end else begin
          grv_on_q = 1'b0;
          // a groove track naming an absent groove falls back to the default speed
          if (song_groove_cfg) speed_q = 8'(DEFAULT_SPEED_VALUE);
          recompute_ratio();
        end
      end
      KIND_WR_ENT: begin
        groove_speed_mem[{req.groove_number, req.entry_position}] = req.param;
      end
      KIND_WR_LEN: begin
        groove_len_mem[req.groove_number] = (req.groove_length > GROOVE_MAX_LENGTH) ?
                                            8'(GROOVE_MAX_LENGTH) : req.groove_length;
      end
      default: begin
      end
    endcase
    res.row_due         = (acc_q <= 0);
    res.current_speed   = speed_q;
    res.current_tempo   = tempo_q;
    res.groove_active   = grv_on_q;
    res.groove_position = grv_pos_q;
  endtask

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // request generation
  // ---------------------------------------------------------------------------

  // a length write first fills every entry it brings into reach
  task automatic queue_request(input tsrt_in_t req);
    tsrt_in_t fill;
    int reach;
    if (req.kind == KIND_WR_LEN) begin
      reach = (req.groove_length > GROOVE_MAX_LENGTH) ? GROOVE_MAX_LENGTH : int'(req.groove_length);
      for (int p = 0; p < reach; p++) begin
        if (!written_map[{req.groove_number, 7'(p)}]) begin
          fill                = tsrt_in_t'($urandom);
          fill.kind           = KIND_WR_ENT;
          fill.groove_number  = req.groove_number;
          fill.entry_position = 7'(p);
          written_map[{req.groove_number, 7'(p)}] = 1'b1;
          pending_requests.push_back(fill);
        end
      end
    end
    if (req.kind == KIND_WR_ENT) written_map[{req.groove_number, req.entry_position}] = 1'b1;
    pending_requests.push_back(req);
  endtask

  function automatic tsrt_in_t make_request(input logic [2:0] kind, input logic [7:0] param,
                                            input logic [4:0] gnum, input logic [6:0] pos,
                                            input logic [7:0] glen);
    tsrt_in_t req;
    req.kind           = kind;
    req.param          = param;
    req.groove_number  = gnum;
    req.entry_position = pos;
    req.groove_length  = glen;
    return req;
  endfunction

  // sampled at the falling edge, when every handshake signal is settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_timer_states.size() != 0)
      @(negedge clk);
  endtask

  // all five registers in index order, valid held high across the writes
  task automatic apply_settings(input logic [7:0] fr, input logic [7:0] sp,
                                input logic [7:0] tp, input logic [7:0] sd, input logic gv);
    logic [2:0] regs [0:4];
    logic [7:0] vals [0:4];
    regs = '{CFG_FRAME_RATE, CFG_SPLIT, CFG_SONG_TEMPO, CFG_SONG_SPEED, CFG_SONG_GRV};
    vals = '{fr, sp, tp, sd, {7'd0, gv}};
    @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    frame_rate_cfg  = fr;
    split_cfg       = sp;
    song_tempo_cfg  = tp;
    song_speed_cfg  = sd;
    song_groove_cfg = gv;
    @(negedge clk);
  endtask

  // one setting: a track load, then mostly ticks and row steps with effects,
  // groove changes and table writes mixed in
  task automatic run_phase(input logic [7:0] fr, input logic [7:0] sp, input logic [7:0] tp,
                           input logic [7:0] sd, input logic gv, input int count);
    tsrt_in_t req;
    int pick;
    apply_settings(fr, sp, tp, sd, gv);
    req      = tsrt_in_t'($urandom);
    req.kind = KIND_LOAD;
    queue_request(req);
    for (int n = 0; n < count; n++) begin
      req  = tsrt_in_t'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        req.kind = KIND_TICK;
      end else if (pick < 52) begin
        req.kind = KIND_STEP;
      end else if (pick < 64) begin
        req.kind = KIND_EFFECT;
        // half of the effects sit just around the split point
        if ($urandom_range(0, 1) != 0) req.param = split_cfg + 8'($urandom_range(0, 2)) - 8'd1;
      end else if (pick < 74) begin
        req.kind = KIND_GROOVE;
        if ($urandom_range(0, 3) != 0) req.param = 8'($urandom_range(0, GROOVE_COUNT - 1));
      end else if (pick < 78) begin
        req.kind = KIND_LOAD;
      end else if (pick < 86) begin
        req.kind = KIND_WR_ENT;
      end else if (pick < 94) begin
        req.kind          = KIND_WR_LEN;
        req.groove_length = 8'($urandom_range(0, 8));
        // long grooves stay on the last groove, whose table is already full
        if ($urandom_range(0, 6) == 0) begin
          req.groove_length = 8'($urandom_range(9, 255));
          req.groove_number = 5'(GROOVE_COUNT - 1);
        end
      end else begin
        req.kind = KIND_SPARE;
      end
      queue_request(req);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  function automatic int draw_pause(input bit steady);
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_pause <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_pause != 0) begin
        in_valid <= 1'b0;
        in_pause <= in_pause - 1;
      end else if (pending_requests.size() != 0) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
        in_pause <= draw_pause(in_steady);
        // switch now and then between gappy and back-to-back stretches
        if ($urandom_range(0, 31) == 0) in_steady <= !in_steady;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: ready with random stalls, plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : receiver_hold
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && pending_requests.size() >= 40) begin
      // plenty still queued, so the block backs up and stalls its input
      hold_cycles <= HOLD_LENGTH;
      hold_done   <= 1'b1;
    end
  end

  always @(posedge clk) begin : receiver_ready
    int pause;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_pause <= 0;
    end else if (hold_cycles != 0) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      pause = draw_pause(out_steady);
      out_pause <= pause;
      out_ready <= (pause == 0);
      if ($urandom_range(0, 31) == 0) out_steady <= !out_steady;
    end else if (out_pause != 0) begin
      out_pause <= out_pause - 1;
      out_ready <= (out_pause == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checker: results first, so a result never meets an expectation from the
  // request accepted at the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    tsrt_out_t want;
    if (!rst_n) begin
      frame_rate_cfg  = RST_FRAME_RATE;
      split_cfg       = RST_SPLIT;
      song_tempo_cfg  = RST_SONG_TEMPO;
      song_speed_cfg  = RST_SONG_SPEED;
      song_groove_cfg = 1'b0;
      acc_q     = 16'sd0;
      tempo_q   = 8'(RESET_TEMPO);
      speed_q   = 8'(DEFAULT_SPEED_VALUE);
      grv_on_q  = 1'b0;
      grv_sel_q = 5'd0;
      grv_pos_q = 7'd0;
      for (int g = 0; g < GROOVE_COUNT; g++) groove_len_mem[g] = 8'd0;
      recompute_ratio();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_timer_states.size() == 0) begin
          report_fault("result with no request outstanding");
        end else begin
          want = expected_timer_states.pop_front();
          if (out_data.row_due !== want.row_due ||
              out_data.current_speed !== want.current_speed ||
              out_data.current_tempo !== want.current_tempo ||
              out_data.groove_active !== want.groove_active ||
              out_data.groove_position !== want.groove_position)
            report_fault($sformatf({"result mismatch: expected due=%0d speed=%0d tempo=%0d ",
                                    "groove=%0d pos=%0d, got due=%0d speed=%0d tempo=%0d ",
                                    "groove=%0d pos=%0d"},
                                   want.row_due, want.current_speed, want.current_tempo,
                                   want.groove_active, want.groove_position,
                                   out_data.row_due, out_data.current_speed,
                                   out_data.current_tempo, out_data.groove_active,
                                   out_data.groove_position));
        end
      end
      if (in_valid && in_ready) begin
        advance_row_timer(in_data, want);
        expected_timer_states.push_back(want);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, no groove yet
    queue_request(make_request(KIND_TICK,   8'd0,   5'd0, 7'd0, 8'd0));
    queue_request(make_request(KIND_STEP,   8'd0,   5'd0, 7'd0, 8'd0));    // no groove
    queue_request(make_request(KIND_SPARE,  8'hff, 5'h1f, 7'h7f, 8'hff));  // unused kind
    queue_request(make_request(KIND_EFFECT, 8'd31,  5'd0, 7'd0, 8'd0));    // just under split
    queue_request(make_request(KIND_EFFECT, 8'd32,  5'd0, 7'd0, 8'd0));    // at split, tempo
    queue_request(make_request(KIND_EFFECT, 8'd0,   5'd0, 7'd0, 8'd0));    // speed zero
    queue_request(make_request(KIND_EFFECT, 8'd255, 5'd0, 7'd0, 8'd0));    // top tempo
    queue_request(make_request(KIND_TICK,   8'd0,   5'd0, 7'd0, 8'd0));
    queue_request(make_request(KIND_TICK,   8'd0,   5'd0, 7'd0, 8'd0));
    // groove 0: speeds 1, 255, 0
    queue_request(make_request(KIND_WR_ENT, 8'd1,   5'd0, 7'd0, 8'd0));
    queue_request(make_request(KIND_WR_ENT, 8'd255, 5'd0, 7'd1, 8'd0));
    queue_request(make_request(KIND_WR_ENT, 8'd0,   5'd0, 7'd2, 8'd0));
    queue_request(make_request(KIND_WR_LEN, 8'd0,   5'd0, 7'd0, 8'd3));
    queue_request(make_request(KIND_GROOVE, 8'd0,   5'd0, 7'd0, 8'd0));
    queue_request(make_request(KIND_STEP,   8'd0,   5'd0, 7'd0, 8'd0));
    queue_request(make_request(KIND_STEP,   8'd0,   5'd0, 7'd0, 8'd0));    // wraps
    queue_request(make_request(KIND_GROOVE, 8'd5,   5'd0, 7'd0, 8'd0));    // absent groove
    queue_request(make_request(KIND_GROOVE, 8'd200, 5'd0, 7'd0, 8'd0));    // beyond the table
    // length dropped to zero under the running groove
    queue_request(make_request(KIND_WR_LEN, 8'd0,   5'd0, 7'd0, 8'd0));
    queue_request(make_request(KIND_STEP,   8'd0,   5'd0, 7'd0, 8'd0));
    queue_request(make_request(KIND_EFFECT, 8'd10,  5'd0, 7'd0, 8'd0));    // speed ends groove
    queue_request(make_request(KIND_WR_LEN, 8'd0,   5'd0, 7'd0, 8'd2));
    queue_request(make_request(KIND_LOAD,   8'd0,   5'd0, 7'd0, 8'd0));
    queue_request(make_request(KIND_TICK,   8'd0,   5'd0, 7'd0, 8'd0));
    wait_drained();

    // a handful of short grooves and one over-long length that saturates
    for (int g = 1; g < 8; g++)
      queue_request(make_request(KIND_WR_LEN, 8'($urandom), 5'(g), 7'($urandom),
                                 8'($urandom_range(1, 8))));
    queue_request(make_request(KIND_WR_LEN, 8'($urandom), 5'(GROOVE_COUNT - 1), 7'($urandom),
                               8'd200));
    wait_drained();

    // slowest frame rate against the fastest ratio drives the count to its floor
    run_phase(8'd1,   8'd0,   8'd255, 8'd1,  1'b0, 90);
    // speed-only timing with speed zero
    run_phase(8'd255, 8'd255, 8'd0,   8'd0,  1'b0, 90);
    run_phase(8'd60,  8'd32,  8'd150, 8'd3,  1'b1, 90);
    run_phase(8'd200, 8'd128, 8'd90,  8'(GROOVE_COUNT - 1), 1'b1, 90);
    // groove track naming a groove that cannot exist
    run_phase(8'd100, 8'd64,  8'd125, 8'd77, 1'b1, 90);
    run_phase(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
              8'($urandom_range(0, GROOVE_COUNT - 1)), 1'b1, 90);
    run_phase(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom), 90);
    run_phase(RST_FRAME_RATE, RST_SPLIT, RST_SONG_TEMPO, RST_SONG_SPEED, 1'b0, 90);

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_timer_states.size() != 0)
      report_fault($sformatf("%0d results never arrived", expected_timer_states.size()));
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tsrt_pkg.sv
design/tsrt_div.sv
design/tempo_speed_row_timer_unit.sv
sim/tempo_speed_row_timer_unit_test.sv
